### rtl/btmx_pkg.sv
// Shared types and constants for the binary trie maximum-XOR block.
// Used by the controller, the datapath and the top level; depends on nothing.
package btmx_pkg;

	localparam int KEY_BITS       = 31;
	localparam int NODES_DEF      = 65536;
	localparam int COUNT_BITS_DEF = 16;
	localparam int LVL_W          = $clog2(KEY_BITS);
	localparam int MISS_W         = $clog2(KEY_BITS + 1);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]          operation;
		logic [KEY_BITS-1:0] key;
	} in_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] max_xor;
		logic [1:0]          status;
	} out_t;

	typedef enum logic [3:0] {
		A_NONE,
		A_LOAD,
		A_RD,
		A_I1,
		A_I2RST,
		A_I2,
		A_TAKE,
		A_LINK,
		A_LINC,
		A_D,
		A_LDEC,
		A_PSET,
		A_PEV,
		A_Q,
		A_OUT
	} act_t;

	typedef struct packed {
		act_t       act;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       nx_zero;
		logic       alt_zero;
		logic       last;
		logic       full;
		logic       cnt_zero;
		logic       cnt_one;
		logic       prune_stop;
		logic       out_free;
	} stat_t;

endpackage

### rtl/btmx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module btmx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/btmx_ctrl.sv
// Sequencing state machine for the trie block: walks, node allocation and pruning.
// Depends on btmx_pkg; drives the datapath through cmd_t and reads back stat_t.
module btmx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  btmx_pkg::stat_t   stat,
	output btmx_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_I1_RD, S_I1_EV, S_I_CHK, S_I2_RD, S_I2_EV, S_I_TAKE, S_I_LINK,
		S_L_RD, S_L_EV, S_D_RD, S_D_EV, S_DL_RD, S_DL_EV, S_P_SET, S_P_RD,
		S_P_EV, S_Q_RD, S_Q_EV, S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] code_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.code = code_q;
		case (state_q)
			S_IDLE:   cmd.act = in_valid ? btmx_pkg::A_LOAD : btmx_pkg::A_NONE;
			S_I1_RD, S_I2_RD, S_L_RD, S_D_RD, S_DL_RD, S_P_RD, S_Q_RD:
				cmd.act = btmx_pkg::A_RD;
			S_I1_EV:  cmd.act = btmx_pkg::A_I1;
			S_I_CHK:  cmd.act = btmx_pkg::A_I2RST;
			S_I2_EV:  cmd.act = btmx_pkg::A_I2;
			S_I_TAKE: cmd.act = btmx_pkg::A_TAKE;
			S_I_LINK: cmd.act = btmx_pkg::A_LINK;
			S_L_EV:   cmd.act = btmx_pkg::A_LINC;
			S_D_EV:   cmd.act = btmx_pkg::A_D;
			S_DL_EV:  cmd.act = btmx_pkg::A_LDEC;
			S_P_SET:  cmd.act = btmx_pkg::A_PSET;
			S_P_EV:   cmd.act = btmx_pkg::A_PEV;
			S_Q_EV:   cmd.act = btmx_pkg::A_Q;
			S_DONE:   cmd.act = stat.out_free ? btmx_pkg::A_OUT : btmx_pkg::A_NONE;
			default:  cmd.act = btmx_pkg::A_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= btmx_pkg::ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						code_q <= btmx_pkg::ST_DONE;
						case (stat.op)
							btmx_pkg::OP_INSERT: state_q <= S_I1_RD;
							btmx_pkg::OP_DELETE: state_q <= S_D_RD;
							btmx_pkg::OP_QUERY:  state_q <= S_Q_RD;
							default:             state_q <= S_DONE;
						endcase
					end
				end
				S_I1_RD: state_q <= S_I1_EV;
				S_I1_EV: state_q <= (stat.nx_zero || stat.last) ? S_I_CHK : S_I1_RD;
				S_I_CHK: begin
					if (stat.full) begin
						code_q  <= btmx_pkg::ST_FULL;
						state_q <= S_DONE;
					end else begin
						state_q <= S_I2_RD;
					end
				end
				S_I2_RD: state_q <= S_I2_EV;
				S_I2_EV: begin
					if (stat.nx_zero) begin
						state_q <= S_I_TAKE;
					end else begin
						state_q <= stat.last ? S_L_RD : S_I2_RD;
					end
				end
				S_I_TAKE: state_q <= S_I_LINK;
				S_I_LINK: state_q <= stat.last ? S_L_RD : S_I2_RD;
				S_L_RD:   state_q <= S_L_EV;
				S_L_EV:   state_q <= S_DONE;
				S_D_RD:   state_q <= S_D_EV;
				S_D_EV: begin
					if (stat.nx_zero) begin
						code_q  <= btmx_pkg::ST_ABSENT;
						state_q <= S_DONE;
					end else begin
						state_q <= stat.last ? S_DL_RD : S_D_RD;
					end
				end
				S_DL_RD: state_q <= S_DL_EV;
				S_DL_EV: begin
					if (stat.cnt_zero) begin
						code_q  <= btmx_pkg::ST_ABSENT;
						state_q <= S_DONE;
					end else begin
						state_q <= stat.cnt_one ? S_P_SET : S_DONE;
					end
				end
				S_P_SET: state_q <= S_P_RD;
				S_P_RD:  state_q <= S_P_EV;
				S_P_EV:  state_q <= stat.prune_stop ? S_DONE : S_P_SET;
				S_Q_RD:  state_q <= S_Q_EV;
				S_Q_EV: begin
					if ((stat.nx_zero && stat.alt_zero) || stat.last) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_Q_RD;
					end
				end
				S_DONE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/btmx_dp.sv
// Datapath of the trie block: node memory, free-node stack, delete path and result register.
// Depends on btmx_pkg and btmx_ram; acts on cmd_t from the controller.
module btmx_dp #(
	parameter int NODES      = btmx_pkg::NODES_DEF,
	parameter int COUNT_BITS = btmx_pkg::COUNT_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  btmx_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output btmx_pkg::out_t  out_data,
	input  btmx_pkg::cmd_t  cmd,
	output btmx_pkg::stat_t stat
);

	localparam int KB  = btmx_pkg::KEY_BITS;
	localparam int LW  = btmx_pkg::LVL_W;
	localparam int MW  = btmx_pkg::MISS_W;
	localparam int NW  = $clog2(NODES);
	localparam int FW  = $clog2(NODES + 1);
	localparam int NDW = 2 * NW + COUNT_BITS;

	logic [KB-1:0]         key_q;
	logic [1:0]            op_q;
	logic [LW-1:0]         lvl_q;
	logic [NW-1:0]         cur_q;
	logic [NW-1:0]         new_q;
	logic [NW-1:0]         node_q;
	logic [KB-1:0]         res_q;
	logic [MW-1:0]         missing_q;
	logic [FW-1:0]         free_cnt_q;
	logic [FW-1:0]         low_q;
	logic [NW-1:0]         root0_q, root1_q;
	logic [NW-1:0]         path_q [KB];

	logic [NDW-1:0]        nrd;
	logic                  nwe;
	logic [NW-1:0]         nwaddr;
	logic [NDW-1:0]        nwdata;
	logic [NW-1:0]         srd;
	logic                  swe;

	logic                  is_root, last, b;
	logic [NW-1:0]         l0, l1, link_b, link_nb, new_node, link_val;
	logic [COUNT_BITS-1:0] cnt, cnt_new;
	logic [FW-1:0]         sidx_fw;
	logic [NW-1:0]         sidx;
	logic                  fresh;

	assign is_root = (cur_q == '0);
	assign last    = (lvl_q == LW'(KB - 1));
	assign b       = key_q[LW'(KB - 1) - lvl_q];
	assign l0      = is_root ? root0_q : nrd[NW-1:0];
	assign l1      = is_root ? root1_q : nrd[2*NW-1:NW];
	assign cnt     = nrd[NDW-1:2*NW];
	assign link_b  = b ? l1 : l0;
	assign link_nb = b ? l0 : l1;

	// Stack entries below the lowest fill level reached since reset still hold their
	// reset contents, which are computed rather than stored.
	assign sidx_fw  = free_cnt_q - FW'(1);
	assign sidx     = sidx_fw[NW-1:0];
	assign fresh    = (sidx_fw < low_q);
	assign new_node = fresh ? (NW'(NODES - 1) - sidx) : srd;

	always_comb begin
		link_val = '0;
		cnt_new  = cnt;
		nwe      = 1'b0;
		nwaddr   = cur_q;
		case (cmd.act)
			btmx_pkg::A_TAKE: begin
				nwe    = 1'b1;
				nwaddr = new_node;
			end
			btmx_pkg::A_LINK: begin
				nwe      = !is_root;
				link_val = new_q;
			end
			btmx_pkg::A_LINC: begin
				nwe     = 1'b1;
				cnt_new = (cnt == '1) ? cnt : cnt + COUNT_BITS'(1);
			end
			btmx_pkg::A_LDEC: begin
				nwe     = (cnt != '0);
				cnt_new = cnt - COUNT_BITS'(1);
			end
			btmx_pkg::A_PEV: begin
				nwe = !is_root;
			end
			default: nwe = 1'b0;
		endcase
		if (cmd.act == btmx_pkg::A_TAKE) begin
			nwdata = '0;
		end else if (cmd.act == btmx_pkg::A_LINK || cmd.act == btmx_pkg::A_PEV) begin
			nwdata = {cnt, (b ? link_val : l1), (b ? l0 : link_val)};
		end else begin
			nwdata = {cnt_new, l1, l0};
		end
	end

	assign swe = (cmd.act == btmx_pkg::A_PSET);

	btmx_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (nwe),
		.waddr (nwaddr),
		.wdata (nwdata),
		.re    (cmd.act == btmx_pkg::A_RD),
		.raddr (cur_q),
		.rdata (nrd)
	);

	btmx_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free_ram (
		.clk   (clk),
		.we    (swe),
		.waddr (free_cnt_q[NW-1:0]),
		.wdata (node_q),
		.re    (cmd.act == btmx_pkg::A_I2),
		.raddr (sidx),
		.rdata (srd)
	);

	always_comb begin
		stat.op         = in_data.operation;
		stat.nx_zero    = (link_b == '0);
		stat.alt_zero   = (link_nb == '0);
		stat.last       = last;
		stat.full       = (FW'(missing_q) > free_cnt_q);
		stat.cnt_zero   = (cnt == '0);
		stat.cnt_one    = (cnt == COUNT_BITS'(1));
		stat.prune_stop = is_root || (link_nb != '0);
		stat.out_free   = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q <= FW'(NODES - 1);
			low_q      <= FW'(NODES - 1);
			root0_q    <= '0;
			root1_q    <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cmd.act == btmx_pkg::A_TAKE) begin
				free_cnt_q <= sidx_fw;
				if (fresh) begin
					low_q <= sidx_fw;
				end
			end else if (swe) begin
				free_cnt_q <= free_cnt_q + FW'(1);
			end
			if (is_root && cmd.act == btmx_pkg::A_LINK) begin
				if (b) root1_q <= new_q;
				else   root0_q <= new_q;
			end else if (is_root && cmd.act == btmx_pkg::A_PEV) begin
				if (b) root1_q <= '0;
				else   root0_q <= '0;
			end
			if (cmd.act == btmx_pkg::A_OUT) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.act)
			btmx_pkg::A_LOAD: begin
				key_q <= in_data.key;
				op_q  <= in_data.operation;
				lvl_q <= '0;
				cur_q <= '0;
				res_q <= '0;
			end
			btmx_pkg::A_I1: begin
				missing_q <= (link_b == '0) ? (MW'(KB) - MW'(lvl_q)) : '0;
				if (link_b != '0 && !last) begin
					cur_q <= link_b;
					lvl_q <= lvl_q + LW'(1);
				end
			end
			btmx_pkg::A_I2RST: begin
				cur_q <= '0;
				lvl_q <= '0;
			end
			btmx_pkg::A_I2: begin
				if (link_b != '0) begin
					cur_q <= link_b;
					if (!last) lvl_q <= lvl_q + LW'(1);
				end
			end
			btmx_pkg::A_TAKE: new_q <= new_node;
			btmx_pkg::A_LINK: begin
				cur_q <= new_q;
				if (!last) lvl_q <= lvl_q + LW'(1);
			end
			btmx_pkg::A_D: begin
				path_q[lvl_q] <= cur_q;
				if (link_b != '0) begin
					cur_q <= link_b;
					if (!last) lvl_q <= lvl_q + LW'(1);
				end
			end
			btmx_pkg::A_LDEC: begin
				node_q <= cur_q;
				lvl_q  <= LW'(KB - 1);
			end
			btmx_pkg::A_PSET: cur_q <= path_q[lvl_q];
			btmx_pkg::A_PEV: begin
				node_q <= cur_q;
				if (!(is_root || link_nb != '0)) lvl_q <= lvl_q - LW'(1);
			end
			btmx_pkg::A_Q: begin
				if (link_b == '0 && link_nb == '0) begin
					// Dead end: every remaining lower bit of the result is set.
					res_q <= res_q | ({KB{1'b1}} >> lvl_q);
				end else begin
					if (link_nb != '0) begin
						res_q[LW'(KB - 1) - lvl_q] <= 1'b1;
						cur_q <= link_nb;
					end else begin
						cur_q <= link_b;
					end
					if (!last) lvl_q <= lvl_q + LW'(1);
				end
			end
			btmx_pkg::A_OUT: begin
				out_data.max_xor <= (op_q == btmx_pkg::OP_QUERY) ? res_q : '0;
				out_data.status  <= cmd.code;
			end
			default: ;
		endcase
	end

endmodule

### rtl/binary_trie_max_xor.sv
// Top level of the binary trie maximum-XOR block: controller plus datapath.
// Depends on btmx_pkg, btmx_ctrl, btmx_dp and btmx_ram.
//
// Holds a multiset of 31-bit keys in a trie of NODES pooled nodes and takes one
// insert, delete or query beat at a time, giving one result beat for each. Every
// trie level is handled as a registered read of node memory followed by a step that
// acts on it; a delete then prunes emptied nodes with a set, read and act step for
// each. An insert first walks down to the first missing link to check that the pool
// can hold the missing nodes, and then makes a building walk that takes and links a
// new node for each missing level. The result sits in an output register, so the
// next beat is taken while a result still waits. Node 0 lives in registers and the
// free-node stack is addressed by a low-water mark, so no clearing pass follows reset.
module binary_trie_max_xor #(
	parameter int NODES      = btmx_pkg::NODES_DEF,
	parameter int COUNT_BITS = btmx_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  btmx_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output btmx_pkg::out_t out_data
);

	btmx_pkg::cmd_t  cmd;
	btmx_pkg::stat_t stat;

	btmx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	btmx_dp #(.NODES(NODES), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

### verif/binary_trie_max_xor_test.sv
// Testbench for binary_trie_max_xor: random and directed insert, delete and query beats
// checked against a trie model kept in this file. Depends on btmx_pkg and the RTL.
module binary_trie_max_xor_test;

	localparam int KB        = btmx_pkg::KEY_BITS;
	localparam int POOL      = btmx_pkg::NODES_DEF;
	localparam int CNT_MAX   = (1 << btmx_pkg::COUNT_BITS_DEF) - 1;
	// Operation code 3 is unused and must give an empty result.
	localparam logic [1:0] OP_SPARE = 2'd3;

	class trie_scoreboard;
		int unsigned kid0[POOL];
		int unsigned kid1[POOL];
		int unsigned leaves[POOL];
		int unsigned spare[POOL];
		int unsigned spare_cnt;
		btmx_pkg::out_t pending[$];
		int errors;

		function void clear();
			for (int i = 0; i < POOL; i++) begin
				kid0[i] = 0;
				kid1[i] = 0;
				leaves[i] = 0;
			end
			for (int i = 0; i + 1 < POOL; i++)
				spare[i] = POOL - 1 - i;
			spare_cnt = POOL - 1;
			errors = 0;
		endfunction

		function int unsigned kid(int unsigned n, bit b);
			return b ? kid1[n] : kid0[n];
		endfunction

		function void set_kid(int unsigned n, bit b, int unsigned v);
			if (b)
				kid1[n] = v;
			else
				kid0[n] = v;
		endfunction

		function logic [1:0] add_key(logic [KB-1:0] k);
			int unsigned cur;
			int unsigned need;
			int unsigned n;
			cur = 0;
			need = 0;
			for (int lv = 0; lv < KB; lv++) begin
				if (kid(cur, k[KB-1-lv]) == 0) begin
					need = KB - lv;
					break;
				end
				cur = kid(cur, k[KB-1-lv]);
			end
			if (need > spare_cnt)
				return btmx_pkg::ST_FULL;
			cur = 0;
			for (int lv = 0; lv < KB; lv++) begin
				if (kid(cur, k[KB-1-lv]) == 0) begin
					spare_cnt--;
					n = spare[spare_cnt];
					kid0[n] = 0;
					kid1[n] = 0;
					leaves[n] = 0;
					set_kid(cur, k[KB-1-lv], n);
				end
				cur = kid(cur, k[KB-1-lv]);
			end
			if (leaves[cur] < CNT_MAX)
				leaves[cur]++;
			return btmx_pkg::ST_DONE;
		endfunction

		function logic [1:0] remove_key(logic [KB-1:0] k);
			int unsigned path[KB+1];
			int unsigned cur;
			int unsigned par;
			cur = 0;
			path[0] = 0;
			for (int lv = 0; lv < KB; lv++) begin
				if (kid(cur, k[KB-1-lv]) == 0)
					return btmx_pkg::ST_ABSENT;
				cur = kid(cur, k[KB-1-lv]);
				path[lv+1] = cur;
			end
			if (leaves[cur] == 0)
				return btmx_pkg::ST_ABSENT;
			leaves[cur]--;
			if (leaves[cur] != 0)
				return btmx_pkg::ST_DONE;
			for (int lv = KB; lv > 0; lv--) begin
				par = path[lv-1];
				if (spare_cnt < POOL) begin
					spare[spare_cnt] = path[lv];
					spare_cnt++;
				end
				set_kid(par, k[KB-lv], 0);
				if (par == 0 || kid0[par] != 0 || kid1[par] != 0)
					break;
			end
			return btmx_pkg::ST_DONE;
		endfunction

		function logic [KB-1:0] best_xor(logic [KB-1:0] k);
			logic [KB-1:0] r;
			int unsigned cur;
			bit b;
			cur = 0;
			r = '0;
			for (int lv = 0; lv < KB; lv++) begin
				b = k[KB-1-lv];
				if (kid(cur, !b) != 0) begin
					r[KB-1-lv] = 1'b1;
					cur = kid(cur, !b);
				end else if (kid(cur, b) != 0) begin
					cur = kid(cur, b);
				end else begin
					for (int j = lv; j < KB; j++)
						r[KB-1-j] = 1'b1;
					break;
				end
			end
			return r;
		endfunction

		function void note_input(btmx_pkg::in_t beat);
			btmx_pkg::out_t e;
			e.max_xor = '0;
			e.status = btmx_pkg::ST_DONE;
			case (beat.operation)
				btmx_pkg::OP_INSERT: e.status = add_key(beat.key);
				btmx_pkg::OP_DELETE: e.status = remove_key(beat.key);
				btmx_pkg::OP_QUERY: e.max_xor = best_xor(beat.key);
				default: ;
			endcase
			pending.push_back(e);
		endfunction

		function void check_result(btmx_pkg::out_t got);
			btmx_pkg::out_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected: max_xor %0h status %0d",
					got.max_xor, got.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.max_xor !== e.max_xor) begin
				$error("max_xor: expected %0h, actual %0h", e.max_xor, got.max_xor);
				errors++;
			end
			if (got.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	btmx_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	btmx_pkg::out_t out_data;

	trie_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off;
	logic [KB-1:0] key_pool[$];

	binary_trie_max_xor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Receiver: decides ready at each falling edge, checks at the rising edge.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// Valid stays high between back-to-back beats and drops only in an idle cycle.
	task automatic send_beat(logic [1:0] op, logic [KB-1:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{operation: op, key: k};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(in_data);
		@(negedge clk);
	endtask

	function automatic logic [KB-1:0] pick_key();
		logic [KB-1:0] k;
		logic [31:0] raw;
		int sel;
		sel = $urandom_range(9);
		if (key_pool.size() > 0 && sel < 5) begin
			k = key_pool[$urandom_range(key_pool.size() - 1)];
		end else if (sel < 7) begin
			raw = $urandom_range(31);
			k = raw[KB-1:0];
		end else begin
			raw = $urandom();
			k = raw[KB-1:0];
		end
		return k;
	endfunction

	task automatic random_phase(int count);
		logic [KB-1:0] k;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			k = pick_key();
			if (r < 40) begin
				send_beat(btmx_pkg::OP_INSERT, k);
				if (key_pool.size() < 64)
					key_pool.push_back(k);
			end else if (r < 65) begin
				send_beat(btmx_pkg::OP_DELETE, k);
			end else if (r < 97) begin
				send_beat(btmx_pkg::OP_QUERY, k);
			end else begin
				send_beat(OP_SPARE, k);
			end
		end
	endtask

	initial begin
		#50000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		hold_off = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty query, absent delete, extremes, unused operation.
		send_beat(btmx_pkg::OP_QUERY, '0);
		send_beat(btmx_pkg::OP_DELETE, 31'h7FFF_FFFF);
		send_beat(btmx_pkg::OP_INSERT, '0);
		send_beat(btmx_pkg::OP_QUERY, 31'h7FFF_FFFF);
		send_beat(btmx_pkg::OP_QUERY, '0);
		send_beat(btmx_pkg::OP_INSERT, 31'h7FFF_FFFF);
		send_beat(btmx_pkg::OP_INSERT, 31'h7FFF_FFFF);
		send_beat(btmx_pkg::OP_QUERY, 31'h2AAA_AAAA);
		send_beat(btmx_pkg::OP_DELETE, 31'h7FFF_FFFF);
		send_beat(btmx_pkg::OP_QUERY, '0);
		send_beat(btmx_pkg::OP_DELETE, 31'h7FFF_FFFF);
		send_beat(btmx_pkg::OP_QUERY, '0);
		send_beat(btmx_pkg::OP_DELETE, 31'h7FFF_FFFE);
		send_beat(OP_SPARE, 31'h5555_5555);
		send_beat(btmx_pkg::OP_INSERT, 31'h4000_0000);
		send_beat(btmx_pkg::OP_QUERY, 31'h4000_0000);
		send_beat(btmx_pkg::OP_DELETE, '0);
		send_beat(btmx_pkg::OP_QUERY, 31'h1234_5678);
		send_beat(btmx_pkg::OP_DELETE, 31'h4000_0000);
		send_beat(btmx_pkg::OP_QUERY, 31'h1234_5678);
		send_beat(btmx_pkg::OP_INSERT, '0);

		// Long receiver hold-off while the sender keeps offering beats.
		hold_off = 400;
		random_phase(20);

		random_phase(350);
		send_idle_pct = 86;
		random_phase(350);
		send_idle_pct = 0;
		recv_stall_pct = 86;
		random_phase(350);
		send_idle_pct = 20;
		recv_stall_pct = 20;
		random_phase(350);
		recv_stall_pct = 0;
		in_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
